/* hdl/two_integer_line_command_parser_defines.svh */
// ----------------------------------------------------------------------------
// Two-integer line command parser: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TWO_INTEGER_LINE_COMMAND_PARSER_DEFINES_SVH
`define TWO_INTEGER_LINE_COMMAND_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define TILCP_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TILCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TILCP_ASSERT(label, ante, cons, msg)
`define TILCP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* hdl/tilcp_pkg.sv */
// ----------------------------------------------------------------------------
// Two-integer line command parser package
// Character codes, command format between front and back, shared sizes.
// ----------------------------------------------------------------------------
package tilcp_pkg;

    localparam int DEFAULT_LINE_LIMIT = 30;

    localparam logic [7:0] CHAR_NUL     = 8'd0;
    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_CR      = 8'd13;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_PLUS    = 8'd43;
    localparam logic [7:0] CHAR_MINUS   = 8'd45;
    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_NINE    = 8'd57;

    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int CMD_PTR_W       = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
    localparam int CMD_CNT_W       = $clog2(CMD_QUEUE_DEPTH + 1);

    localparam int VALUE_W  = 32;
    localparam int OUT_DATA_W = 72;

    typedef enum logic [2:0] {
        CMD_SPACE,
        CMD_SIGN,
        CMD_DIGIT,
        CMD_WS,
        CMD_OTHER,
        CMD_EOL
    } cmd_kind_t;

    // arg: digit value, sign negative in bit 0, or line overflow in bit 0.
    typedef struct packed {
        cmd_kind_t  kind;
        logic [3:0] arg;
    } cmd_t;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } phase_t;

endpackage

/* hdl/tilcp_front.sv */
// ----------------------------------------------------------------------------
// Front end
// Accepts bytes, enforces the line limit and the zero-byte text end, and
// turns each parsable byte into a command for the back end.
// ----------------------------------------------------------------------------
module tilcp_front
    import tilcp_pkg::*;
#(
    parameter int LINE_LIMIT = DEFAULT_LINE_LIMIT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // rx_byte[7:0]
    input  logic       queue_full,
    output logic       push,
    output cmd_t       cmd
);

    localparam int CNT_W = $clog2(LINE_LIMIT + 1);
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(LINE_LIMIT);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             overflow_reg;
    logic             overflow_next;
    logic             ended_reg;
    logic             ended_next;
    logic             accept;
    logic             cmd_valid;
    logic [7:0]       digit_value;

    assign s_tready    = !queue_full;
    assign accept      = s_tvalid && s_tready;
    assign digit_value = s_tdata - CHAR_ZERO;
    assign push        = accept && cmd_valid;

    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        ended_next    = ended_reg;
        cmd_valid     = 1'b0;
        cmd.kind      = CMD_OTHER;
        cmd.arg       = 4'd0;
        if (s_tdata == CHAR_NEWLINE)
        begin
            cmd_valid     = 1'b1;
            cmd.kind      = CMD_EOL;
            cmd.arg       = {3'd0, overflow_reg};
            count_next    = '0;
            overflow_next = 1'b0;
            ended_next    = 1'b0;
        end
        else if (count_reg >= LIMIT)
        begin
            overflow_next = 1'b1;
        end
        else
        begin
            count_next = count_reg + 1'b1;
            if (!ended_reg)
            begin
                if (s_tdata == CHAR_NUL)
                begin
                    ended_next = 1'b1;
                end
                else
                begin
                    cmd_valid = 1'b1;
                    if (s_tdata == CHAR_SPACE)
                    begin
                        cmd.kind = CMD_SPACE;
                    end
                    else if (s_tdata == CHAR_PLUS || s_tdata == CHAR_MINUS)
                    begin
                        cmd.kind = CMD_SIGN;
                        cmd.arg  = {3'd0, s_tdata == CHAR_MINUS};
                    end
                    else if (s_tdata >= CHAR_ZERO && s_tdata <= CHAR_NINE)
                    begin
                        cmd.kind = CMD_DIGIT;
                        cmd.arg  = digit_value[3:0];
                    end
                    else if (s_tdata >= CHAR_TAB && s_tdata <= CHAR_CR)
                    begin
                        cmd.kind = CMD_WS;
                    end
                    else
                    begin
                        cmd.kind = CMD_OTHER;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            ended_reg    <= 1'b0;
        end
        else if (accept)
        begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            ended_reg    <= ended_next;
        end
    end

endmodule

/* hdl/tilcp_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// Command queue
// Short register queue between front and back end.
// ----------------------------------------------------------------------------
`include "two_integer_line_command_parser_defines.svh"

module tilcp_cmd_fifo
    import tilcp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head
);

    localparam logic [CMD_PTR_W-1:0] LAST_PTR = CMD_PTR_W'(CMD_QUEUE_DEPTH - 1);
    localparam logic [CMD_CNT_W-1:0] DEPTH    = CMD_CNT_W'(CMD_QUEUE_DEPTH);

    cmd_t                 entry_reg [CMD_QUEUE_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg;
    logic [CMD_CNT_W-1:0] count_next;

    assign full      = (count_reg == DEPTH);
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `TILCP_ASSERT(a_count_bound, 1'b1, count_reg <= DEPTH, "command queue count out of range")
    `TILCP_ASSERT(a_pop_nonempty, pop, count_reg != '0, "command popped from empty queue")
    `TILCP_ASSERT(a_push_space, push, count_reg != DEPTH, "command pushed into full queue")

endmodule

/* hdl/tilcp_back.sv */
// ----------------------------------------------------------------------------
// Back end
// Executes commands: token tracking, atoi conversion of the first two
// tokens, and the registered result stage on end of line.
// ----------------------------------------------------------------------------
`include "two_integer_line_command_parser_defines.svh"

module tilcp_back
    import tilcp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  cmd_t                  cmd,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata   // first_value[31:0], second_value[63:32],
                                            // tokens_found[65:64], line_too_long[66]
);

    logic [1:0]         tn_reg;
    logic [1:0]         tn_next;
    logic               in_token_reg;
    logic               in_token_next;
    phase_t             phase_reg;
    phase_t             phase_next;
    logic               neg_reg;
    logic               neg_next;
    logic [VALUE_W-1:0] acc1_reg;
    logic [VALUE_W-1:0] acc1_next;
    logic [VALUE_W-1:0] acc2_reg;
    logic [VALUE_W-1:0] acc2_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [VALUE_W-1:0] out_first_reg;
    logic [VALUE_W-1:0] out_second_reg;
    logic [1:0]         out_tokens_reg;
    logic               out_long_reg;

    logic               is_eol;
    logic               is_char;
    logic               starting;
    logic [1:0]         tn_eff;
    phase_t             phase_eff;
    logic               neg_eff;
    logic               active;
    logic               do_digit;
    logic [VALUE_W-1:0] acc_sel;
    logic [VALUE_W-1:0] scaled;
    logic [VALUE_W-1:0] digit_ext;
    logic [VALUE_W-1:0] acc_new;
    logic               load_out;

    assign is_eol   = (cmd.kind == CMD_EOL);
    assign is_char  = (cmd.kind == CMD_SIGN) || (cmd.kind == CMD_DIGIT) ||
                      (cmd.kind == CMD_WS) || (cmd.kind == CMD_OTHER);
    assign pop      = cmd_valid && (!is_eol || !out_valid_reg || m_tready);
    assign load_out = pop && is_eol;

    // A non-space byte outside a token opens a new one before it is parsed.
    assign starting  = !in_token_reg;
    assign tn_eff    = (starting && tn_reg != 2'd3) ? tn_reg + 2'd1 : tn_reg;
    assign phase_eff = starting ? PH_SKIP : phase_reg;
    assign neg_eff   = starting ? 1'b0 : neg_reg;
    assign active    = (tn_eff == 2'd1) || (tn_eff == 2'd2);
    assign do_digit  = pop && active && (cmd.kind == CMD_DIGIT) && (phase_eff != PH_DONE);

    assign acc_sel   = (tn_eff == 2'd2) ? acc2_reg : acc1_reg;
    assign scaled    = (acc_sel << 3) + (acc_sel << 1);
    assign digit_ext = {{(VALUE_W - 4){1'b0}}, cmd.arg};
    assign acc_new   = neg_eff ? scaled - digit_ext : scaled + digit_ext;

    // Conversion phase of the current token.
    always_comb
    begin
        phase_next = phase_reg;
        if (pop && is_eol)
        begin
            phase_next = PH_SKIP;
        end
        else if (pop && is_char)
        begin
            phase_next = phase_eff;
            if (active)
            begin
                case (phase_eff)
                    PH_SKIP:
                    begin
                        case (cmd.kind)
                            CMD_SIGN:  phase_next = PH_SIGN;
                            CMD_DIGIT: phase_next = PH_DIGITS;
                            CMD_OTHER: phase_next = PH_DONE;
                            default:   phase_next = PH_SKIP;
                        endcase
                    end
                    PH_SIGN,
                    PH_DIGITS:
                    begin
                        phase_next = (cmd.kind == CMD_DIGIT) ? PH_DIGITS : PH_DONE;
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        tn_next       = tn_reg;
        in_token_next = in_token_reg;
        neg_next      = neg_reg;
        acc1_next     = acc1_reg;
        acc2_next     = acc2_reg;
        if (pop)
        begin
            case (cmd.kind)
                CMD_EOL:
                begin
                    tn_next       = 2'd0;
                    in_token_next = 1'b0;
                    neg_next      = 1'b0;
                    acc1_next     = '0;
                    acc2_next     = '0;
                end
                CMD_SPACE:
                begin
                    in_token_next = 1'b0;
                end
                default:
                begin
                    tn_next       = tn_eff;
                    in_token_next = 1'b1;
                    neg_next      = neg_eff;
                    if (active && phase_eff == PH_SKIP && cmd.kind == CMD_SIGN)
                    begin
                        neg_next = cmd.arg[0];
                    end
                    if (do_digit && tn_eff == 2'd1)
                    begin
                        acc1_next = acc_new;
                    end
                    if (do_digit && tn_eff == 2'd2)
                    begin
                        acc2_next = acc_new;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tn_reg        <= 2'd0;
            in_token_reg  <= 1'b0;
            phase_reg     <= PH_SKIP;
            neg_reg       <= 1'b0;
            acc1_reg      <= '0;
            acc2_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tn_reg        <= tn_next;
            in_token_reg  <= in_token_next;
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            acc1_reg      <= acc1_next;
            acc2_reg      <= acc2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_first_reg  <= acc1_reg;
            out_second_reg <= acc2_reg;
            out_tokens_reg <= (tn_reg == 2'd3) ? 2'd2 : tn_reg;
            out_long_reg   <= cmd.arg[0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - 2 * VALUE_W - 3){1'b0}}, out_long_reg, out_tokens_reg,
                       out_second_reg, out_first_reg};

    `TILCP_ASSERT_NEXT(a_eol_shows, load_out, out_valid_reg, "line end did not load a result")
    `TILCP_ASSERT_NEXT(a_eol_clears, load_out, tn_reg == 2'd0 && !in_token_reg,
                       "line end did not clear token state")
    `TILCP_ASSERT(a_no_overwrite, out_valid_reg && !m_tready, !load_out,
                  "result overwritten while stalled")

endmodule

/* hdl/two_integer_line_command_parser.sv */
// ----------------------------------------------------------------------------
// Two-integer line command parser
// Parses the first two signed decimal tokens of each text line.
// ----------------------------------------------------------------------------
// Usage:
// Text bytes enter on the s_tvalid/s_tready/s_tdata stream, one item per
// byte. Each newline produces one result item on m_tvalid/m_tready/m_tdata
// holding both integers, the token count and the line-too-long flag; other
// bytes produce no result.
// One byte is accepted every cycle while the command queue is not full.
// The front end classifies a byte in the cycle it is accepted and pushes
// its command into a two-entry command queue; the back end executes each
// command from the queue head and loads the result register on a newline.
// When the receiver stalls, the result is held in the output register and
// the back end stops only at the next newline; bytes keep being accepted
// until the command queue fills, then s_tready drops.
// Reset clears all line state, the queue and the output valid flag; the
// block is ready as soon as reset is released.
// Bytes beyond LINE_LIMIT on a line are dropped and flag the result.
// ----------------------------------------------------------------------------
module two_integer_line_command_parser
    import tilcp_pkg::*;
#(
    parameter int LINE_LIMIT = DEFAULT_LINE_LIMIT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // rx_byte[7:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // first_value[31:0], second_value[63:32],
                                             // tokens_found[65:64], line_too_long[66]
);

    logic push;
    cmd_t push_cmd;
    logic queue_full;
    logic pop;
    logic queue_not_empty;
    cmd_t head_cmd;

    tilcp_front #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    tilcp_cmd_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head      (head_cmd)
    );

    tilcp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_not_empty),
        .cmd       (head_cmd),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
